FILE: src/wacd_pkg.sv
// shared types and constants for the windowed average change detector
// used by every module of the block; no dependencies
package wacd_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned AVG_W      = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned MAX_WINDOW = 256;

  // dividend is |sum| scaled by 16
  localparam int unsigned DVD_W     = SUM_W + 4;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned REM_W     = CNT_W + 1;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = CFG_IDX_W'(1);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_BASELINE  = 2'd1,
    ST_NO_CHANGE = 2'd2,
    ST_CHANGE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [CNT_W-1:0] window_length;
    logic [THR_W-1:0] change_threshold;
  } cfg_t;

  // one finished window handed from front to back
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } win_t;

endpackage

FILE: src/wacd_front.sv
// front end: accumulates valid samples and closes windows
// depends on wacd_pkg
module wacd_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic signed [wacd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 sample_ok_i,
  input  logic [wacd_pkg::CNT_W-1:0]           window_length_i,
  output logic                                 push_o,
  output wacd_pkg::win_t                       win_o
);

  logic signed [wacd_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [wacd_pkg::CNT_W-1:0]        valid_q, valid_d;
  logic [wacd_pkg::CNT_W-1:0]        seen_q, seen_d;
  logic [wacd_pkg::CNT_W-1:0]        eff_len;
  logic signed [wacd_pkg::SUM_W:0]   sum_wide;
  logic signed [wacd_pkg::SUM_W-1:0] sum_new;
  logic [wacd_pkg::CNT_W-1:0]        valid_new;
  logic [wacd_pkg::CNT_W-1:0]        seen_new;

  always_comb begin
    if (window_length_i == '0) begin
      eff_len = wacd_pkg::CNT_W'(1);
    end else if (window_length_i > wacd_pkg::CNT_W'(wacd_pkg::MAX_WINDOW)) begin
      eff_len = wacd_pkg::CNT_W'(wacd_pkg::MAX_WINDOW);
    end else begin
      eff_len = window_length_i;
    end
  end

  always_comb begin
    sum_wide = (wacd_pkg::SUM_W+1)'(sum_q)
             + (wacd_pkg::SUM_W+1)'(sample_i);
    sum_new   = sum_q;
    valid_new = valid_q;
    if (sample_ok_i) begin
      // saturate the running sum
      if (sum_wide > (wacd_pkg::SUM_W+1)'(wacd_pkg::SUM_MAX)) begin
        sum_new = wacd_pkg::SUM_MAX;
      end else if (sum_wide < (wacd_pkg::SUM_W+1)'(wacd_pkg::SUM_MIN)) begin
        sum_new = wacd_pkg::SUM_MIN;
      end else begin
        sum_new = sum_wide[wacd_pkg::SUM_W-1:0];
      end
      if (valid_q != '1) begin
        valid_new = valid_q + 1'b1;
      end
    end
    seen_new = (seen_q != '1) ? seen_q + 1'b1 : seen_q;

    push_o    = 1'b0;
    win_o.sum   = sum_new;
    win_o.count = valid_new;
    sum_d   = sum_q;
    valid_d = valid_q;
    seen_d  = seen_q;
    if (accept_i) begin
      if (seen_new >= eff_len) begin
        push_o  = 1'b1;
        sum_d   = '0;
        valid_d = '0;
        seen_d  = '0;
      end else begin
        sum_d   = sum_new;
        valid_d = valid_new;
        seen_d  = seen_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      valid_q <= '0;
      seen_q  <= '0;
    end else begin
      sum_q   <= sum_d;
      valid_q <= valid_d;
      seen_q  <= seen_d;
    end
  end

endmodule

FILE: src/wacd_queue.sv
// two-entry queue of finished windows between front and back end
// depends on wacd_pkg
module wacd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wacd_pkg::win_t wr_data_i,
  input  logic           pop_i,
  output wacd_pkg::win_t rd_data_o,
  output logic           full_o,
  output logic           empty_o
);

  wacd_pkg::win_t                mem_q [wacd_pkg::QDEPTH];
  logic [wacd_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [wacd_pkg::QCNT_W-1:0]   count_q;

  assign full_o    = (count_q == wacd_pkg::QCNT_W'(wacd_pkg::QDEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= wacd_pkg::QCNT_W'(wacd_pkg::QDEPTH))
    else $error("queue count out of range");
  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count not advanced on push");
`endif

endmodule

FILE: src/wacd_back.sv
// back end: shared restoring divider, baseline compare and output register
// depends on wacd_pkg
module wacd_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wacd_pkg::win_t                     win_i,
  input  logic                               empty_i,
  output logic                               pop_o,
  input  logic [wacd_pkg::THR_W-1:0]         change_threshold_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic signed [wacd_pkg::AVG_W-1:0]  average_o,
  output logic [wacd_pkg::AVG_W-1:0]         difference_o
);

  wacd_pkg::back_state_e state_q, state_d;

  logic [wacd_pkg::DVD_W-1:0]     dvd_q, dvd_d;
  logic [wacd_pkg::REM_W-1:0]     rem_q, rem_d;
  logic [wacd_pkg::CNT_W-1:0]     divisor_q, divisor_d;
  logic [wacd_pkg::DIV_CNT_W-1:0] step_q, step_d;
  logic                           neg_q, neg_d;
  logic                           empty_q, empty_d;

  logic signed [wacd_pkg::AVG_W-1:0] base_q, base_d;
  logic                              base_valid_q, base_valid_d;

  logic                              out_valid_q, out_valid_d;
  wacd_pkg::status_e                 out_status_q, out_status_d;
  logic signed [wacd_pkg::AVG_W-1:0] out_avg_q, out_avg_d;
  logic [wacd_pkg::AVG_W-1:0]        out_diff_q, out_diff_d;

  logic [wacd_pkg::SUM_W-1:0]        abs_sum;
  logic [wacd_pkg::REM_W-1:0]        rem_sh;
  logic                              rem_ge;
  logic                              out_free;
  logic signed [wacd_pkg::AVG_W-1:0] avg;
  logic signed [wacd_pkg::AVG_W:0]   delta;
  logic [wacd_pkg::AVG_W:0]          delta_abs;
  logic [wacd_pkg::AVG_W-1:0]        diff;

  assign abs_sum  = win_i.sum[wacd_pkg::SUM_W-1] ? wacd_pkg::SUM_W'(-win_i.sum)
                                                 : wacd_pkg::SUM_W'(win_i.sum);
  assign rem_sh   = {rem_q[wacd_pkg::REM_W-2:0], dvd_q[wacd_pkg::DVD_W-1]};
  assign rem_ge   = (rem_sh >= wacd_pkg::REM_W'(divisor_q));
  assign out_free = !out_valid_q || !out_stall_i;

  // quotient magnitude sits in dvd_q after the last step; clamp to Q12.4
  always_comb begin
    if (neg_q) begin
      if (dvd_q > wacd_pkg::DVD_W'(32768)) begin
        avg = {1'b1, {(wacd_pkg::AVG_W-1){1'b0}}};
      end else begin
        avg = -wacd_pkg::AVG_W'(dvd_q);
      end
    end else begin
      if (dvd_q > wacd_pkg::DVD_W'(32767)) begin
        avg = {1'b0, {(wacd_pkg::AVG_W-1){1'b1}}};
      end else begin
        avg = wacd_pkg::AVG_W'(dvd_q);
      end
    end
    delta     = (wacd_pkg::AVG_W+1)'(avg) - (wacd_pkg::AVG_W+1)'(base_q);
    delta_abs = delta[wacd_pkg::AVG_W] ? (wacd_pkg::AVG_W+1)'(-delta)
                                       : (wacd_pkg::AVG_W+1)'(delta);
    diff      = delta_abs[wacd_pkg::AVG_W-1:0];
  end

  always_comb begin
    state_d      = state_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    divisor_d    = divisor_q;
    step_d       = step_q;
    neg_d        = neg_q;
    empty_d      = empty_q;
    base_d       = base_q;
    base_valid_d = base_valid_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_avg_d    = out_avg_q;
    out_diff_d   = out_diff_q;
    pop_o        = 1'b0;

    unique case (state_q)
      wacd_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          empty_d   = (win_i.count == '0);
          neg_d     = win_i.sum[wacd_pkg::SUM_W-1];
          dvd_d     = {abs_sum, 4'b0000};
          divisor_d = win_i.count;
          rem_d     = '0;
          step_d    = '0;
          state_d   = (win_i.count == '0) ? wacd_pkg::BK_DONE : wacd_pkg::BK_DIVIDE;
        end
      end
      wacd_pkg::BK_DIVIDE: begin
        rem_d  = rem_ge ? rem_sh - wacd_pkg::REM_W'(divisor_q) : rem_sh;
        dvd_d  = {dvd_q[wacd_pkg::DVD_W-2:0], rem_ge};
        step_d = step_q + 1'b1;
        if (step_q == wacd_pkg::DIV_CNT_W'(wacd_pkg::DIV_STEPS - 1)) begin
          state_d = wacd_pkg::BK_DONE;
        end
      end
      wacd_pkg::BK_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = wacd_pkg::BK_IDLE;
          if (empty_q) begin
            out_status_d = wacd_pkg::ST_EMPTY;
            out_avg_d    = '0;
            out_diff_d   = '0;
          end else if (!base_valid_q) begin
            out_status_d = wacd_pkg::ST_BASELINE;
            out_avg_d    = avg;
            out_diff_d   = '0;
            base_d       = avg;
            base_valid_d = 1'b1;
          end else if (diff > change_threshold_i) begin
            out_status_d = wacd_pkg::ST_CHANGE;
            out_avg_d    = avg;
            out_diff_d   = diff;
            base_d       = '0;
            base_valid_d = 1'b0;
          end else begin
            out_status_d = wacd_pkg::ST_NO_CHANGE;
            out_avg_d    = avg;
            out_diff_d   = diff;
            base_d       = avg;
          end
        end
      end
      default: begin
        state_d = wacd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wacd_pkg::BK_IDLE;
      base_q       <= '0;
      base_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      base_q       <= base_d;
      base_valid_q <= base_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    divisor_q    <= divisor_d;
    step_q       <= step_d;
    neg_q        <= neg_d;
    empty_q      <= empty_d;
    out_status_q <= out_status_d;
    out_avg_q    <= out_avg_d;
    out_diff_q   <= out_diff_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign average_o    = out_avg_q;
  assign difference_o = out_diff_q;

endmodule

FILE: src/windowed_average_change_detector.sv
// Windowed average change detector. Samples are accepted one per cycle while the
// two-entry window queue has room; a window ends on the sample that brings the
// count to the window length (0 counts as 1, above 256 as 256). For each non-empty
// window the back end pops it, runs the 24 steps of the shared restoring divider
// and then compares and loads the output register, while an empty window skips
// the divider (one pop, one load of the output register). The back end takes a new
// window only after it has loaded the result of the last one. The output register
// frees the back end while a result waits.
// depends on wacd_pkg, wacd_front, wacd_queue, wacd_back
module windowed_average_change_detector (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [wacd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [wacd_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [wacd_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                                   sample_ok_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [1:0]                             status_o,
  output logic signed [wacd_pkg::AVG_W-1:0]      average_o,
  output logic [wacd_pkg::AVG_W-1:0]             difference_o
);

  wacd_pkg::cfg_t cfg_q;
  wacd_pkg::win_t push_win, pop_win;
  logic           push, pop, q_full, q_empty, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length    <= wacd_pkg::CNT_W'(16);
      cfg_q.change_threshold <= wacd_pkg::THR_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wacd_pkg::REG_WINDOW_LENGTH: begin
          cfg_q.window_length <= cfg_wdata_i[wacd_pkg::CNT_W-1:0];
        end
        wacd_pkg::REG_CHANGE_THRESHOLD: begin
          cfg_q.change_threshold <= cfg_wdata_i[wacd_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  wacd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .sample_i        (sample_i),
    .sample_ok_i     (sample_ok_i),
    .window_length_i (cfg_q.window_length),
    .push_o          (push),
    .win_o           (push_win)
  );

  wacd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (push_win),
    .pop_i     (pop),
    .rd_data_o (pop_win),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  wacd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .win_i              (pop_win),
    .empty_i            (q_empty),
    .pop_o              (pop),
    .change_threshold_i (cfg_q.change_threshold),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .average_o          (average_o),
    .difference_o       (difference_o)
  );

endmodule
